@@ design/i2p_pkg.sv @@
// Package for the infix to postfix converter: command record, command kinds,
// character constants and the operator precedence function.
// No dependencies.
package i2p_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int CMD_FIFO_DEPTH  = 4;

    localparam logic [7:0] CH_CARET  = 8'h5E;  // '^'
    localparam logic [7:0] CH_SLASH  = 8'h2F;  // '/'
    localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
    localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
    localparam logic [7:0] CH_OPEN   = 8'h28;  // '('
    localparam logic [7:0] CH_CLOSE  = 8'h29;  // ')'
    localparam logic [7:0] CH_LOW_A  = 8'h61;  // 'a'
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;  // 'z'

    localparam logic [1:0] PREC_POW = 2'd3;
    localparam logic [1:0] PREC_MUL = 2'd2;
    localparam logic [1:0] PREC_ADD = 2'd1;
    localparam logic [1:0] PREC_NONE = 2'd0;

    localparam logic [2:0] K_LETTER = 3'd0;
    localparam logic [2:0] K_OPEN   = 3'd1;
    localparam logic [2:0] K_CLOSE  = 3'd2;
    localparam logic [2:0] K_OPER   = 3'd3;
    localparam logic [2:0] K_END    = 3'd4;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] sym;
        logic [1:0] prec;
    } t_cmd;

    function automatic logic [1:0] prec_of(input logic [7:0] c);
        logic [1:0] p;
        unique case (c) inside
            CH_CARET:           p = PREC_POW;
            CH_STAR, CH_SLASH:  p = PREC_MUL;
            CH_PLUS, CH_MINUS:  p = PREC_ADD;
            default:            p = PREC_NONE;
        endcase
        return p;
    endfunction

endpackage

@@ design/i2p_front.sv @@
// Front end of the converter: accepts input beats and classifies each
// character into a command for the back end. Depends on i2p_pkg.
module i2p_front (
    input  logic            i_rst_n,
    input  logic            i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  logic [7:0]      i_s_axis_tdata,   // [7:0] in_symbol
    input  logic            i_s_axis_tlast,   // end_of_expr
    output logic            o_q_wr,
    output i2p_pkg::t_cmd   o_q_cmd,
    input  logic            i_q_full
);

    i2p_pkg::t_cmd w_cmd;

    always_comb begin
        w_cmd.sym  = i_s_axis_tdata;
        w_cmd.prec = i2p_pkg::prec_of(i_s_axis_tdata);
        if (i_s_axis_tlast) begin
            w_cmd.kind = i2p_pkg::K_END;
        end else begin
            unique case (i_s_axis_tdata) inside
                [i2p_pkg::CH_LOW_A:i2p_pkg::CH_LOW_Z]: w_cmd.kind = i2p_pkg::K_LETTER;
                i2p_pkg::CH_OPEN:                      w_cmd.kind = i2p_pkg::K_OPEN;
                i2p_pkg::CH_CLOSE:                     w_cmd.kind = i2p_pkg::K_CLOSE;
                default:                               w_cmd.kind = i2p_pkg::K_OPER;
            endcase
        end
    end

    assign o_s_axis_tready = !i_q_full && i_rst_n;
    assign o_q_wr          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_q_cmd         = w_cmd;

endmodule

@@ design/i2p_cmd_fifo.sv @@
// Short command queue between the front and back ends of the converter.
// Depends on i2p_pkg.
module i2p_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  i2p_pkg::t_cmd   i_wr_cmd,
    output logic            o_full,
    output logic            o_valid,
    output i2p_pkg::t_cmd   o_rd_cmd,
    input  logic            i_rd
);

    localparam int DEPTH = i2p_pkg::CMD_FIFO_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    i2p_pkg::t_cmd  r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic           w_wr, w_rd;

    assign o_full   = (r_count == CW'(DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_rd_cmd = r_mem[r_rd_ptr];
    assign w_wr     = i_wr && !o_full;
    assign w_rd     = i_rd && o_valid;

    always_comb begin
        n_wr_ptr = w_wr ? PW'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = w_rd ? PW'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (w_wr && !w_rd) begin
            n_count = CW'(r_count + 1'b1);
        end else if (!w_wr && w_rd) begin
            n_count = CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

endmodule

@@ design/i2p_back.sv @@
// Back end of the converter: operator stack in a memory, pop sequencer,
// sticky error flags and the output register. Depends on i2p_pkg.
module i2p_back #(
    parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  i2p_pkg::t_cmd   i_q_cmd,
    output logic            o_q_rd,
    output logic            o_m_axis_tvalid,
    input  logic            i_m_axis_tready,
    output logic [15:0]     o_m_axis_tdata,   // [7:0] out_symbol, [9:8] error_status
    output logic            o_m_axis_tlast,   // run_last
    output logic            o_m_axis_tuser    // is_end_marker
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_EV   = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [7:0]     r_stack [STACK_DEPTH];
    logic [7:0]     r_rdata;

    logic [1:0]     r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [1:0]     r_err, n_err;
    i2p_pkg::t_cmd  r_cmd, n_cmd;
    logic           r_found, n_found;
    logic           r_pend_v, n_pend_v;
    logic [7:0]     r_pend_sym, n_pend_sym;

    logic           r_out_v;
    logic [7:0]     r_out_sym;
    logic [1:0]     r_out_err;
    logic           r_out_end;
    logic           r_out_last;

    logic [CW-1:0]  w_cnt_m1;
    logic           w_out_free;
    logic           w_send;
    logic [7:0]     w_send_sym;
    logic [1:0]     w_send_err;
    logic           w_send_end;
    logic           w_send_last;
    logic           w_push;
    logic           w_pop;
    logic           w_emit;
    logic           w_stop;
    logic           w_hit_open;

    assign w_cnt_m1   = CW'(r_count - 1'b1);
    assign w_out_free = !r_out_v || i_m_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_err       = r_err;
        n_cmd       = r_cmd;
        n_found     = r_found;
        n_pend_v    = r_pend_v;
        n_pend_sym  = r_pend_sym;
        o_q_rd      = 1'b0;
        w_send      = 1'b0;
        w_send_sym  = r_pend_sym;
        w_send_err  = 2'b00;
        w_send_end  = 1'b0;
        w_send_last = 1'b0;
        w_push      = 1'b0;
        w_pop       = 1'b0;
        w_emit      = 1'b0;
        w_stop      = 1'b0;
        w_hit_open  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_rd  = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_found = 1'b0;
                    if (i_q_cmd.kind == i2p_pkg::K_LETTER) begin
                        n_pend_v   = 1'b1;
                        n_pend_sym = i_q_cmd.sym;
                    end
                    if ((i_q_cmd.kind == i2p_pkg::K_CLOSE || i_q_cmd.kind == i2p_pkg::K_OPER
                         || i_q_cmd.kind == i2p_pkg::K_END) && r_count != '0) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_RD: begin
                // wait for the registered top-of-stack read
                n_state = S_EV;
            end
            S_EV: begin
                if (r_cmd.kind == i2p_pkg::K_END) begin
                    w_pop  = 1'b1;
                    w_emit = (r_rdata != i2p_pkg::CH_OPEN) && (r_rdata != i2p_pkg::CH_CLOSE);
                end else if (r_cmd.kind == i2p_pkg::K_CLOSE) begin
                    w_pop = 1'b1;
                    if (r_rdata == i2p_pkg::CH_OPEN) begin
                        w_hit_open = 1'b1;
                    end else begin
                        w_emit = 1'b1;
                    end
                end else begin
                    if (r_rdata == i2p_pkg::CH_OPEN
                        || i2p_pkg::prec_of(r_rdata) < r_cmd.prec) begin
                        w_stop = 1'b1;
                    end else begin
                        w_pop  = 1'b1;
                        w_emit = 1'b1;
                    end
                end

                // hold while the previous pending symbol cannot go out
                if (!(w_emit && r_pend_v && !w_out_free)) begin
                    if (w_emit) begin
                        w_send     = r_pend_v;
                        n_pend_v   = 1'b1;
                        n_pend_sym = r_rdata;
                    end
                    if (w_pop) begin
                        n_count = w_cnt_m1;
                    end
                    if (w_hit_open) begin
                        n_found = 1'b1;
                    end
                    if (w_pop && !w_hit_open && !w_stop && w_cnt_m1 != '0) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (r_pend_v) begin
                    if (w_out_free) begin
                        w_send      = 1'b1;
                        w_send_last = (r_cmd.kind != i2p_pkg::K_END);
                        n_pend_v    = 1'b0;
                        if (r_cmd.kind == i2p_pkg::K_LETTER) begin
                            n_state = S_IDLE;
                        end
                    end
                end else if (r_cmd.kind == i2p_pkg::K_END) begin
                    if (w_out_free) begin
                        w_send      = 1'b1;
                        w_send_sym  = 8'h00;
                        w_send_err  = r_err;
                        w_send_end  = 1'b1;
                        w_send_last = 1'b1;
                        n_err       = 2'b00;
                        n_state     = S_IDLE;
                    end
                end else if (r_cmd.kind == i2p_pkg::K_OPEN || r_cmd.kind == i2p_pkg::K_OPER) begin
                    if (r_count < CW'(STACK_DEPTH)) begin
                        w_push  = 1'b1;
                        n_count = CW'(r_count + 1'b1);
                    end else begin
                        n_err[0] = 1'b1;
                    end
                    n_state = S_IDLE;
                end else if (r_cmd.kind == i2p_pkg::K_CLOSE) begin
                    if (!r_found) begin
                        n_err[1] = 1'b1;
                    end
                    n_state = S_IDLE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_err    <= 2'b00;
            r_found  <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_err    <= n_err;
            r_found  <= n_found;
            r_pend_v <= n_pend_v;
            if (w_send) begin
                r_out_v <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_pend_sym <= n_pend_sym;
        if (w_send) begin
            r_out_sym  <= w_send_sym;
            r_out_err  <= w_send_err;
            r_out_end  <= w_send_end;
            r_out_last <= w_send_last;
        end
    end

    // stack memory: one write port, one registered read of the top entry
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_stack[r_count[AW-1:0]] <= r_cmd.sym;
        end
        r_rdata <= r_stack[w_cnt_m1[AW-1:0]];
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {6'b000000, r_out_err, r_out_sym};
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_end;

endmodule

@@ design/infix_to_postfix_converter_unit.sv @@
// Infix to postfix converter, top level: front end, command queue, back end.
// Depends on i2p_pkg, i2p_front, i2p_cmd_fifo and i2p_back.
//
// Takes one character per input beat (tlast marks the end of an expression)
// and streams out the postfix form, one character per output beat, closed by
// an end-marker beat (tuser high) that carries the sticky error flags. tlast
// on the output marks the last beat caused by one input beat. The back-end
// stack sequencer sets the pace: a letter or '(' is read from the queue and
// then finished, and an operator, ')' or end also examines stack entries,
// each with a read of the stack memory and then a decision, and a popped
// operator that still waits goes out at the end. Output stalls hold the
// sequencer. A 4-entry command queue lets input beats arrive while the
// stack is being worked. The stack holds STACK_DEPTH entries; a push on a
// full stack is dropped and flagged.
module infix_to_postfix_converter_unit #(
    parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_symbol
    input  logic        i_s_axis_tlast,   // end_of_expr
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] out_symbol, [9:8] error_status
    output logic        o_m_axis_tlast,   // run_last
    output logic        o_m_axis_tuser    // is_end_marker
);

    logic           w_q_wr;
    i2p_pkg::t_cmd  w_q_wr_cmd;
    logic           w_q_full;
    logic           w_q_valid;
    i2p_pkg::t_cmd  w_q_rd_cmd;
    logic           w_q_rd;

    i2p_front u_front (
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_q_wr          (w_q_wr),
        .o_q_cmd         (w_q_wr_cmd),
        .i_q_full        (w_q_full)
    );

    i2p_cmd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_q_wr),
        .i_wr_cmd (w_q_wr_cmd),
        .o_full   (w_q_full),
        .o_valid  (w_q_valid),
        .o_rd_cmd (w_q_rd_cmd),
        .i_rd     (w_q_rd)
    );

    i2p_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_cmd         (w_q_rd_cmd),
        .o_q_rd          (w_q_rd),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule
